@@ rtl/bcs_pkg.sv @@
package bcs_pkg;

  // Field widths.
  localparam int TIDAL_W  = 7;
  localparam int RATE_W   = 8;
  localparam int IE_W     = 8;
  localparam int PPP_W    = 17;
  localparam int HOLD_W   = 14;
  localparam int HOME_W   = 21;
  localparam int VEL_W    = 24;
  localparam int TARGET_W = 22;
  localparam int PHASE_W  = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  // Datapath widths.
  localparam int VOL_W     = 24;  // tidal times pulses per percent, signed
  localparam int ABS_W     = 23;  // magnitude of the volume
  localparam int NUMER_W   = 33;  // dividend and quotient of the shared divider
  localparam int DVSR_W    = 17;  // divisor of the shared divider
  localparam int QT_W      = 16;  // a period in ms
  localparam int TIME_W    = 17;  // a signed phase time in ms
  localparam int DIV_CNT_W = $clog2(NUMER_W + 1);

  // Constants of the timing math.
  localparam int MINUTE_MS      = 60000;   // one minute in ms
  localparam int MINUTE_MS_X10  = 600000;  // one minute in ms, times the ratio scale
  localparam int IE_BASE        = 10;      // inspiratory share of the scaled ratio
  localparam int MS_PER_S       = 1000;
  localparam logic [VEL_W-1:0] PREHOME_VEL = VEL_W'(1000);
  localparam logic [VEL_W-1:0] VEL_MAX     = {VEL_W{1'b1}};

  // Reset values of the configuration registers.
  localparam logic signed [PPP_W-1:0]  PPP_RESET  = PPP_W'(100);
  localparam logic        [HOLD_W-1:0] HOLD_RESET = HOLD_W'(500);
  localparam logic signed [HOME_W-1:0] HOME_RESET = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PPP  = 2'd0,
    REG_HOLD = 2'd1,
    REG_HOME = 2'd2
  } cfg_reg_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_STARTUP  = 3'd0,
    PH_PREHOME  = 3'd1,
    PH_HOMING   = 3'd2,
    PH_POSTHOME = 3'd3,
    PH_INHALE   = 3'd4,
    PH_PAUSE    = 3'd5,
    PH_EXHALE   = 3'd6
  } phase_t;

  // Datapath operations of one microcode step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_VOLUME,
    OP_PREP,
    OP_START_ALL,
    OP_SAVE_ALL,
    OP_START_IN,
    OP_SAVE_IN,
    OP_START_VIN,
    OP_SAVE_VIN,
    OP_START_VEX,
    OP_SAVE_VEX,
    OP_ZERO_RATE,
    OP_EMIT_MOTION,
    OP_EMIT_SIMPLE
  } op_t;

  // Jump conditions. While the condition holds the step jumps and its operation is held off.
  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_INPUT,
    C_NO_MOTION,
    C_RATE_ZERO,
    C_DIV_BUSY,
    C_OUT_BUSY
  } cond_t;

  typedef logic [3:0] upc_t;

  localparam upc_t U_WAIT        = 4'd0;
  localparam upc_t U_DISPATCH    = 4'd1;
  localparam upc_t U_VOLUME      = 4'd2;
  localparam upc_t U_PREP        = 4'd3;
  localparam upc_t U_DIV_ALL     = 4'd4;
  localparam upc_t U_WAIT_ALL    = 4'd5;
  localparam upc_t U_DIV_IN      = 4'd6;
  localparam upc_t U_WAIT_IN     = 4'd7;
  localparam upc_t U_DIV_VIN     = 4'd8;
  localparam upc_t U_WAIT_VIN    = 4'd9;
  localparam upc_t U_DIV_VEX     = 4'd10;
  localparam upc_t U_WAIT_VEX    = 4'd11;
  localparam upc_t U_ZERO        = 4'd12;
  localparam upc_t U_EMIT_MOTION = 4'd13;
  localparam upc_t U_EMIT_SIMPLE = 4'd14;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  jump;  // taken while the condition holds
    upc_t  next;  // taken otherwise
  } uword_t;

  // The control store.
  function automatic uword_t ucode(upc_t addr);
    uword_t w;
    w = '{op: OP_NONE, cond: C_NEVER, jump: U_WAIT, next: U_WAIT};
    unique case (addr)
      U_WAIT:        w = '{OP_TAKE,        C_NO_INPUT,  U_WAIT,        U_DISPATCH};
      U_DISPATCH:    w = '{OP_NONE,        C_NO_MOTION, U_EMIT_SIMPLE, U_VOLUME};
      U_VOLUME:      w = '{OP_VOLUME,      C_NEVER,     U_PREP,        U_PREP};
      U_PREP:        w = '{OP_PREP,        C_RATE_ZERO, U_ZERO,        U_DIV_ALL};
      U_DIV_ALL:     w = '{OP_START_ALL,   C_NEVER,     U_WAIT_ALL,    U_WAIT_ALL};
      U_WAIT_ALL:    w = '{OP_SAVE_ALL,    C_DIV_BUSY,  U_WAIT_ALL,    U_DIV_IN};
      U_DIV_IN:      w = '{OP_START_IN,    C_NEVER,     U_WAIT_IN,     U_WAIT_IN};
      U_WAIT_IN:     w = '{OP_SAVE_IN,     C_DIV_BUSY,  U_WAIT_IN,     U_DIV_VIN};
      U_DIV_VIN:     w = '{OP_START_VIN,   C_NEVER,     U_WAIT_VIN,    U_WAIT_VIN};
      U_WAIT_VIN:    w = '{OP_SAVE_VIN,    C_DIV_BUSY,  U_WAIT_VIN,    U_DIV_VEX};
      U_DIV_VEX:     w = '{OP_START_VEX,   C_NEVER,     U_WAIT_VEX,    U_WAIT_VEX};
      U_WAIT_VEX:    w = '{OP_SAVE_VEX,    C_DIV_BUSY,  U_WAIT_VEX,    U_EMIT_MOTION};
      U_ZERO:        w = '{OP_ZERO_RATE,   C_NEVER,     U_EMIT_MOTION, U_EMIT_MOTION};
      U_EMIT_MOTION: w = '{OP_EMIT_MOTION, C_OUT_BUSY,  U_EMIT_MOTION, U_WAIT};
      U_EMIT_SIMPLE: w = '{OP_EMIT_SIMPLE, C_OUT_BUSY,  U_EMIT_SIMPLE, U_WAIT};
      default:       w = '{OP_NONE,        C_NEVER,     U_WAIT,        U_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/bcs_if.sv @@
interface bcs_in_if import bcs_pkg::*;;
  logic               valid;
  logic               ready;
  logic               motor_done;
  logic               timer_expired;
  logic [TIDAL_W-1:0] tidal_percent;
  logic [RATE_W-1:0]  breath_rate;
  logic [IE_W-1:0]    ie_ratio_x10;

  modport source (output valid, motor_done, timer_expired, tidal_percent, breath_rate,
                  ie_ratio_x10, input ready);
  modport sink   (input valid, motor_done, timer_expired, tidal_percent, breath_rate,
                  ie_ratio_x10, output ready);
endinterface

interface bcs_out_if import bcs_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [PHASE_W-1:0]         phase;
  logic                       move_issue;
  logic [VEL_W-1:0]           move_velocity;
  logic signed [TARGET_W-1:0] move_target;
  logic                       timer_start;
  logic [HOLD_W-1:0]          timer_ms;
  logic                       timing_error;

  modport source (output valid, phase, move_issue, move_velocity, move_target, timer_start,
                  timer_ms, timing_error, input ready);
  modport sink   (input valid, phase, move_issue, move_velocity, move_target, timer_start,
                  timer_ms, timing_error, output ready);
endinterface

interface bcs_cfg_if import bcs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/breath_cycle_sequencer_unit.sv @@
// Channel   Role    Handshake      Word
// item      sink    valid/ready    one evaluation tick: flags and operator settings
// result    source  valid/ready    phase after the tick and the commands it issues
// cfg       sink    valid/ready    register index and write data
//
// A tick that only steps the phase passes the dispatch and simple emit steps before its
// result enters the output register; the result and the next word can then both be taken.
// A tick that enters inhale runs four divisions on the shared one-bit-per-cycle divider.
// Each division is a start step, a divide step for each of the 33 quotient bits and a save
// step; the sequencer holds meanwhile. The result follows the last save step and the emit
// step, and the next word is taken once the sequencer is back at its wait step. A zero rate
// skips the divisions: the prep step goes to the zero step and then to the emit step.
// Reset is synchronous: phase goes to startup, the stored exhale velocity to zero and
// the registers to their defaults. A stalled result sits in the output register while
// the next word is accepted; the sequencer then waits at its emit step. cfg is always ready.
module breath_cycle_sequencer_unit import bcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  bcs_in_if.sink  item,
  bcs_out_if.source result,
  bcs_cfg_if.sink cfg
);

  // Configuration registers.
  logic signed [PPP_W-1:0]  ppp;
  logic        [HOLD_W-1:0] hold_ms;
  logic signed [HOME_W-1:0] home;

  // Architectural state.
  phase_t           cur_phase;
  logic [VEL_W-1:0] exhale_velocity;

  // Sequencer.
  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;
  logic   cond_hit;
  logic   fire;

  // Latched tick.
  logic               done_q;
  logic               expired_q;
  logic [TIDAL_W-1:0] tidal_q;
  logic [RATE_W-1:0]  rate_q;
  logic [IE_W-1:0]    ie_q;

  // Motion datapath.
  logic signed [VOL_W-1:0]  volume;
  logic [NUMER_W-1:0]       numer;
  logic [DVSR_W-1:0]        den;
  logic [QT_W-1:0]          t_all;
  logic signed [TIME_W-1:0] t_in;
  logic signed [TIME_W-1:0] t_ex;
  logic [VEL_W-1:0]         v_in;
  logic                     err;

  // Shared restoring divider.
  logic [DVSR_W-1:0]    div_rem;
  logic [DVSR_W-1:0]    div_dvsr;
  logic [NUMER_W-1:0]   div_quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DVSR_W:0]      div_trial;
  logic [DVSR_W:0]      div_diff;
  logic                 div_take;

  // Output register.
  logic                       out_valid;
  logic [PHASE_W-1:0]         out_phase;
  logic                       out_mv;
  logic [VEL_W-1:0]           out_vel;
  logic signed [TARGET_W-1:0] out_target;
  logic                       out_tm;
  logic [HOLD_W-1:0]          out_tms;
  logic                       out_err;

  // Combinational helpers.
  logic signed [VOL_W:0]      vol_prod;
  logic [VOL_W-1:0]           vol_neg;
  logic [ABS_W-1:0]           abs_vol;
  logic [NUMER_W-1:0]         numer_prod;
  logic [DVSR_W-1:0]          den_prod;
  logic [QT_W-1:0]            quo_short;
  logic [VEL_W-1:0]           vel_sat;
  logic                       t_in_ok;
  logic                       t_ex_ok;
  logic signed [VOL_W:0]      pos;
  logic                       pos_fits;
  logic signed [TARGET_W-1:0] target_sat;
  logic signed [TARGET_W-1:0] home_ext;
  logic                       motion_tick;
  logic                       out_take;

  // Results of a tick that does not compute motion.
  phase_t                     sim_phase;
  logic                       sim_mv;
  logic [VEL_W-1:0]           sim_vel;
  logic signed [TARGET_W-1:0] sim_target;
  logic                       sim_tm;
  logic [HOLD_W-1:0]          sim_tms;

  assign item.ready = (upc == U_WAIT);
  assign cfg.ready  = 1'b1;
  assign out_take   = out_valid && result.ready;

  assign result.valid         = out_valid;
  assign result.phase         = out_phase;
  assign result.move_issue    = out_mv;
  assign result.move_velocity = out_vel;
  assign result.move_target   = out_target;
  assign result.timer_start   = out_tm;
  assign result.timer_ms      = out_tms;
  assign result.timing_error  = out_err;

  // Arithmetic feeding the datapath registers. Each product lands in a register.
  assign vol_prod   = $signed({1'b0, tidal_q}) * ppp;
  assign vol_neg    = -volume;
  assign abs_vol    = volume[VOL_W-1] ? vol_neg[ABS_W-1:0] : volume[ABS_W-1:0];
  assign numer_prod = NUMER_W'(abs_vol) * NUMER_W'(MS_PER_S);
  assign den_prod   = DVSR_W'(rate_q) * (DVSR_W'(ie_q) + DVSR_W'(IE_BASE));

  assign div_trial = {div_rem, div_quo[NUMER_W-1]};
  assign div_diff  = div_trial - {1'b0, div_dvsr};
  assign div_take  = !div_diff[DVSR_W];

  assign quo_short = div_quo[QT_W-1:0];
  assign vel_sat   = (|div_quo[NUMER_W-1:VEL_W]) ? VEL_MAX : div_quo[VEL_W-1:0];
  assign t_in_ok   = !t_in[TIME_W-1] && (t_in != '0);
  assign t_ex_ok   = !t_ex[TIME_W-1] && (t_ex != '0);

  // Inhale target: volume above home, clamped to the signed target range.
  assign home_ext   = {{(TARGET_W-HOME_W){home[HOME_W-1]}}, home};
  assign pos        = {volume[VOL_W-1], volume} +
                      {{(VOL_W+1-HOME_W){home[HOME_W-1]}}, home};
  assign pos_fits   = (&pos[VOL_W:TARGET_W-1]) || !(|pos[VOL_W:TARGET_W-1]);
  assign target_sat = pos_fits ? pos[TARGET_W-1:0] :
                      (pos[VOL_W] ? {1'b1, {(TARGET_W-1){1'b0}}}
                                  : {1'b0, {(TARGET_W-1){1'b1}}});

  // Posthome always computes motion, exhale only once the move has finished.
  assign motion_tick = (cur_phase == PH_POSTHOME) || ((cur_phase == PH_EXHALE) && done_q);

  // Phase step for every tick that does not enter inhale.
  always_comb begin
    sim_phase  = cur_phase;
    sim_mv     = 1'b0;
    sim_vel    = '0;
    sim_target = '0;
    sim_tm     = 1'b0;
    sim_tms    = '0;
    unique case (cur_phase)
      PH_STARTUP: begin
        sim_phase = PH_PREHOME;
      end
      PH_PREHOME: begin
        sim_phase  = PH_HOMING;
        sim_mv     = 1'b1;
        sim_vel    = PREHOME_VEL;
        sim_target = home_ext;
      end
      PH_HOMING: begin
        if (done_q) begin
          sim_phase = PH_POSTHOME;
        end
      end
      PH_INHALE: begin
        if (done_q) begin
          sim_phase = PH_PAUSE;
          sim_tm    = 1'b1;
          sim_tms   = hold_ms;
        end
      end
      PH_PAUSE: begin
        if (expired_q) begin
          sim_phase  = PH_EXHALE;
          sim_mv     = 1'b1;
          sim_vel    = exhale_velocity;
          sim_target = home_ext;
        end
      end
      PH_POSTHOME, PH_EXHALE: begin
        sim_phase = cur_phase;
      end
      default: begin
        // The unused phase code falls back to startup with no command.
        sim_phase = PH_STARTUP;
      end
    endcase
  end

  // Microsequencer: fetch the control word, evaluate its condition, pick the next step.
  always_comb begin
    uw = ucode(upc);
    unique case (uw.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_NO_INPUT:  cond_hit = !item.valid;
      C_NO_MOTION: cond_hit = !motion_tick;
      C_RATE_ZERO: cond_hit = (rate_q == '0);
      C_DIV_BUSY:  cond_hit = (div_cnt != '0);
      C_OUT_BUSY:  cond_hit = out_valid && !result.ready;
      default:     cond_hit = 1'b0;
    endcase
    fire     = !cond_hit;
    upc_next = cond_hit ? uw.jump : uw.next;
  end

  // Control state, configuration and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc             <= U_WAIT;
      cur_phase       <= PH_STARTUP;
      exhale_velocity <= '0;
      ppp             <= PPP_RESET;
      hold_ms         <= HOLD_RESET;
      home            <= HOME_RESET;
      out_valid       <= 1'b0;
      div_cnt         <= '0;
    end else begin
      upc <= upc_next;
      if (cfg.valid) begin
        case (cfg.index)
          REG_PPP:  ppp     <= cfg.data[PPP_W-1:0];
          REG_HOLD: hold_ms <= cfg.data[HOLD_W-1:0];
          REG_HOME: home    <= cfg.data[HOME_W-1:0];
          default: ;
        endcase
      end
      // A new word loaded in the same cycle as the old one leaves keeps the register full.
      if (fire && (uw.op inside {OP_EMIT_MOTION, OP_EMIT_SIMPLE})) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      if (div_cnt != '0) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (fire) begin
        case (uw.op) inside
          OP_START_ALL, OP_START_IN, OP_START_VIN, OP_START_VEX: begin
            div_cnt <= DIV_CNT_W'(NUMER_W);
          end
          OP_SAVE_VEX: begin
            exhale_velocity <= t_ex_ok ? vel_sat : VEL_MAX;
          end
          OP_ZERO_RATE: begin
            exhale_velocity <= VEL_MAX;
          end
          OP_EMIT_MOTION: begin
            cur_phase <= PH_INHALE;
          end
          OP_EMIT_SIMPLE: begin
            cur_phase <= sim_phase;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, driven by the operation of the current step.
  always_ff @(posedge clk) begin
    if (div_cnt != '0) begin
      div_rem <= div_take ? div_diff[DVSR_W-1:0] : div_trial[DVSR_W-1:0];
      div_quo <= {div_quo[NUMER_W-2:0], div_take};
    end
    if (fire) begin
      case (uw.op)
        OP_TAKE: begin
          done_q    <= item.motor_done;
          expired_q <= item.timer_expired;
          tidal_q   <= item.tidal_percent;
          rate_q    <= item.breath_rate;
          ie_q      <= item.ie_ratio_x10;
        end
        OP_VOLUME: begin
          volume <= vol_prod[VOL_W-1:0];
        end
        OP_PREP: begin
          numer <= numer_prod;
          den   <= den_prod;
          err   <= 1'b0;
        end
        OP_START_ALL: begin
          div_rem  <= '0;
          div_quo  <= NUMER_W'(MINUTE_MS);
          div_dvsr <= DVSR_W'(rate_q);
        end
        OP_SAVE_ALL: begin
          t_all <= quo_short;
        end
        OP_START_IN: begin
          div_rem  <= '0;
          div_quo  <= NUMER_W'(MINUTE_MS_X10);
          div_dvsr <= den;
        end
        OP_SAVE_IN: begin
          // The hold time cancels out of the exhale time.
          t_in <= $signed({1'b0, quo_short}) - $signed(TIME_W'(hold_ms));
          t_ex <= $signed({1'b0, t_all}) - $signed({1'b0, quo_short});
        end
        OP_START_VIN: begin
          div_rem  <= '0;
          div_quo  <= numer;
          div_dvsr <= DVSR_W'(t_in[QT_W-1:0]);
        end
        OP_SAVE_VIN: begin
          v_in <= t_in_ok ? vel_sat : VEL_MAX;
          if (!t_in_ok) begin
            err <= 1'b1;
          end
        end
        OP_START_VEX: begin
          div_rem  <= '0;
          div_quo  <= numer;
          div_dvsr <= DVSR_W'(t_ex[QT_W-1:0]);
        end
        OP_SAVE_VEX: begin
          if (!t_ex_ok) begin
            err <= 1'b1;
          end
        end
        OP_ZERO_RATE: begin
          v_in <= VEL_MAX;
          err  <= 1'b1;
        end
        OP_EMIT_MOTION: begin
          out_phase  <= PH_INHALE;
          out_mv     <= 1'b1;
          out_vel    <= v_in;
          out_target <= target_sat;
          out_tm     <= 1'b0;
          out_tms    <= '0;
          out_err    <= err;
        end
        OP_EMIT_SIMPLE: begin
          out_phase  <= sim_phase;
          out_mv     <= sim_mv;
          out_vel    <= sim_vel;
          out_target <= sim_target;
          out_tm     <= sim_tm;
          out_tms    <= sim_tms;
          out_err    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule
